// ===== design/osset_pkg.sv =====
// Package for the order-statistic set: operation codes, read selects, controller/datapath structs.
`default_nettype none

package osset_pkg;

	// Default width of a key; the universe is 0 .. 2^KEY_BITS - 1
	localparam int KEY_BITS_DEF = 10;

	// Operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_KTH    = 2'd2;
	localparam logic [1:0] OP_COUNT  = 2'd3;

	// Which tree node the datapath reads this cycle
	typedef logic [1:0] rd_sel_t;
	localparam rd_sel_t RD_NODE      = 2'd0; // current node
	localparam rd_sel_t RD_PARENT    = 2'd1; // parent of current node
	localparam rd_sel_t RD_LEFT      = 2'd2; // left child of current node
	localparam rd_sel_t RD_NEXT_LEFT = 2'd3; // left child of the node chosen this cycle

	// Commands from controller to datapath
	typedef struct packed {
		logic    clr_wr;    // clearing pass: zero one node
		logic    load;      // capture the input transfer
		logic    upd_wr;    // write node +/- 1 and climb
		logic    kth_step;  // descend one level for kth
		logic    cnt_step;  // descend one level for count
		logic    cnt_acc;   // add pending left-sibling count
		logic    res_kth;   // result: key found by kth
		logic    res_bad;   // result: invalid rank
		logic    res_cnt;   // result: count below key
		logic    out_load;  // move result into the output register
		rd_sel_t rd_sel;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;     // last node of the clearing pass
		logic leaf_change;  // insert of absent key or delete of present key
		logic kth_bad;      // rank zero or above member count
		logic at_root;      // current node is the root
		logic last_lvl;     // final level of a descent
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== design/osset_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none

module osset_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 16,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/osset_dp.sv =====
// Datapath of the order-statistic set: count tree memory, node walker, rank and sum registers.
`default_nettype none

module osset_dp #(
	parameter int KEY_BITS = osset_pkg::KEY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            op,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [KEY_BITS:0]     rank,
	output logic [KEY_BITS:0]     answer,
	output logic                  invalid,
	input  osset_pkg::dp_cmd_t    cmd,
	output osset_pkg::dp_sts_t    sts
);
	import osset_pkg::*;

	localparam int NW    = KEY_BITS + 1;          // node address and count width
	localparam int LVL_W = $clog2(KEY_BITS);

	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [NW-1:0]       rem_q;
	logic [NW-1:0]       node_q;
	logic [LVL_W-1:0]    lvl_q;
	logic                bit_q;
	logic [NW-1:0]       sum_q;
	logic [NW-1:0]       clr_q;
	logic [NW-1:0]       res_ans_q;
	logic                res_bad_q;
	logic [NW-1:0]       answer_q;
	logic                invalid_q;

	logic [NW-1:0]       rd_data;
	logic [NW-1:0]       rd_addr;
	logic                wr_en;
	logic [NW-1:0]       wr_addr;
	logic [NW-1:0]       wr_data;
	logic                kth_le;
	logic [NW-1:0]       kth_next;
	logic                key_bit;
	logic [NW-1:0]       sum_nxt;

	// Count tree in heap order, node 1 is the root, leaf of key x is 2^KEY_BITS + x
	osset_ram #(
		.WIDTH (NW),
		.DEPTH (2 ** NW)
	) u_tree (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Kth descent decision on the left child count just read
	assign kth_le   = rem_q <= rd_data;
	assign kth_next = {node_q[KEY_BITS-1:0], ~kth_le};

	// Count descent: key bit of this level, and sum with the pending left sibling
	assign key_bit = key_q[lvl_q];
	assign sum_nxt = sum_q + (bit_q ? rd_data : '0);

	// Read address select
	always_comb begin
		unique case (cmd.rd_sel)
			RD_NODE:      rd_addr = node_q;
			RD_PARENT:    rd_addr = {1'b0, node_q[NW-1:1]};
			RD_LEFT:      rd_addr = {node_q[NW-2:0], 1'b0};
			RD_NEXT_LEFT: rd_addr = {kth_next[NW-2:0], 1'b0};
		endcase
	end

	// Write port: clearing pass or +/- 1 on the climb
	assign wr_en   = cmd.clr_wr | cmd.upd_wr;
	assign wr_addr = cmd.clr_wr ? clr_q : node_q;
	assign wr_data = cmd.clr_wr ? '0 :
	                 (op_q == OP_INSERT) ? rd_data + NW'(1) : rd_data - NW'(1);

	// Status
	assign sts.clr_last    = &clr_q;
	assign sts.leaf_change = (op_q == OP_INSERT && rd_data == '0) ||
	                         (op_q == OP_DELETE && rd_data != '0);
	assign sts.kth_bad     = (rem_q == '0) || (rem_q > rd_data);
	assign sts.at_root     = node_q == NW'(1);
	assign sts.last_lvl    = lvl_q == '0;

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + NW'(1);
		end
	end

	// Item registers and tree walker
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			key_q <= key;
			rem_q <= rank;
			node_q <= (op == OP_INSERT || op == OP_DELETE) ? {1'b1, key} : NW'(1);
			lvl_q <= LVL_W'(KEY_BITS - 1);
			bit_q <= 1'b0;
			sum_q <= '0;
		end else begin
			if (cmd.upd_wr) begin
				node_q <= {1'b0, node_q[NW-1:1]};
			end
			if (cmd.kth_step) begin
				node_q <= kth_next;
				rem_q  <= kth_le ? rem_q : rem_q - rd_data;
				lvl_q  <= lvl_q - LVL_W'(1);
			end
			if (cmd.cnt_step) begin
				node_q <= {node_q[NW-2:0], key_bit};
				bit_q  <= key_bit;
				lvl_q  <= lvl_q - LVL_W'(1);
			end
			if (cmd.cnt_acc) begin
				sum_q <= sum_nxt;
			end
		end
	end

	// Pending result
	always_ff @(posedge clk) begin
		if (cmd.res_kth) begin
			res_ans_q <= {1'b0, kth_next[KEY_BITS-1:0]};
			res_bad_q <= 1'b0;
		end else if (cmd.res_bad) begin
			res_ans_q <= '0;
			res_bad_q <= 1'b1;
		end else if (cmd.res_cnt) begin
			res_ans_q <= sum_nxt;
			res_bad_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			answer_q  <= res_ans_q;
			invalid_q <= res_bad_q;
		end
	end

	assign answer  = answer_q;
	assign invalid = invalid_q;

endmodule

`default_nettype wire

// ===== design/osset_ctrl.sv =====
// Controller of the order-statistic set: sequences clearing, tree climbs and descents, output.
`default_nettype none

module osset_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	output logic               out_valid,
	input  logic               out_ready,
	output osset_pkg::dp_cmd_t cmd,
	input  osset_pkg::dp_sts_t sts
);
	import osset_pkg::*;

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_ULEAF  = 4'd2;
	localparam logic [3:0] S_UCHK   = 4'd3;
	localparam logic [3:0] S_UWALK  = 4'd4;
	localparam logic [3:0] S_KROOT  = 4'd5;
	localparam logic [3:0] S_KCHK   = 4'd6;
	localparam logic [3:0] S_KDESC  = 4'd7;
	localparam logic [3:0] S_CWALK  = 4'd8;
	localparam logic [3:0] S_CDRAIN = 4'd9;
	localparam logic [3:0] S_PUSH   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (op) inside
						OP_INSERT, OP_DELETE: state_nxt = S_ULEAF;
						OP_KTH:               state_nxt = S_KROOT;
						default:              state_nxt = S_CWALK;
					endcase
				end
			end
			S_ULEAF: begin
				cmd.rd_sel = RD_NODE;
				state_nxt  = S_UCHK;
			end
			S_UCHK: begin
				if (sts.leaf_change) begin
					cmd.upd_wr = 1'b1;
					cmd.rd_sel = RD_PARENT;
					state_nxt  = S_UWALK;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_UWALK: begin
				cmd.upd_wr = 1'b1;
				cmd.rd_sel = RD_PARENT;
				if (sts.at_root) state_nxt = S_IDLE;
			end
			S_KROOT: begin
				cmd.rd_sel = RD_NODE;
				state_nxt  = S_KCHK;
			end
			S_KCHK: begin
				if (sts.kth_bad) begin
					cmd.res_bad = 1'b1;
					state_nxt   = S_PUSH;
				end else begin
					cmd.rd_sel = RD_LEFT;
					state_nxt  = S_KDESC;
				end
			end
			S_KDESC: begin
				cmd.kth_step = 1'b1;
				cmd.rd_sel   = RD_NEXT_LEFT;
				if (sts.last_lvl) begin
					cmd.res_kth = 1'b1;
					state_nxt   = S_PUSH;
				end
			end
			S_CWALK: begin
				cmd.cnt_step = 1'b1;
				cmd.cnt_acc  = 1'b1;
				cmd.rd_sel   = RD_LEFT;
				if (sts.last_lvl) state_nxt = S_CDRAIN;
			end
			S_CDRAIN: begin
				cmd.res_cnt = 1'b1;
				state_nxt   = S_PUSH;
			end
			S_PUSH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output valid: set on load, cleared when the result is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// A transfer in always leaves the block busy next cycle
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// A result appears only from the output push
	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_PUSH)
		else $error("output valid raised outside push");

	// A pending result is held while the output slot is occupied
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUSH && out_valid_q && !out_ready |=> state_q == S_PUSH)
		else $error("pending result dropped");

	// No result push during the clearing pass
	a_no_out_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !cmd.out_load && !in_ready)
		else $error("activity during clearing pass");

endmodule

`default_nettype wire

// ===== design/order_statistic_set.sv =====
// Order-statistic set over keys 0 .. 2^KEY_BITS - 1: count tree in RAM, controller and datapath.
// Insert/delete read the leaf, then climb to the root writing +/- 1 (no climb if the set is unchanged);
// kth checks the rank against the root count, then descends to a leaf; count descends summing left siblings.
// Throughput: one item at a time, one tree level a cycle; a result push waits while the output is held.
// Reset: arst_n clears control, then a clearing pass zeroes every tree node with in_ready low.
`default_nettype none

module order_statistic_set #(
	parameter int KEY_BITS = osset_pkg::KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [KEY_BITS-1:0] key,
	input  logic [KEY_BITS:0]   rank,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [KEY_BITS:0]   answer,
	output logic                invalid
);
	import osset_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	osset_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	osset_dp #(
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.key     (key),
		.rank    (rank),
		.answer  (answer),
		.invalid (invalid),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

`default_nettype wire
